[src/rbi_pkg.sv]
package rbi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int DIST_W    = 31;
   localparam int EPS_W     = 16;
   localparam int NUM_W     = COORD_W + 1;
   localparam int SAT_SHIFT = DIST_W - FRAC_BITS;
   localparam int DIV_STEPS = DIST_W;
   localparam int PROD_W    = 2 * COORD_W;

   localparam logic [DIST_W-1:0] T_MAX     = {DIST_W{1'b1}};
   localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(66);

   localparam logic CSR_IGNORE_INSIDE = 1'b0;
   localparam logic CSR_EPSILON       = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0] o;
      coord_type [2:0] d;
      coord_type [2:0] lo;
      coord_type [2:0] hi;
   } item_type;

   typedef struct packed {
      logic [NUM_W-1:0]   n;
      logic [COORD_W-1:0] dm;
      logic [COORD_W-1:0] rem;
      logic [DIST_W-1:0]  quot;
      logic               pos;
      logic               sat;
   } div_type;

endpackage

[src/ray_box_intersect_top.sv]
// Requests pass the entry, divider, multiply, check and output registers, one transfer
// per cycle while no result waits; the 31-stage restoring divider sets the depth.
// The whole pipeline holds while a presented result waits, so nothing is lost.
// Reset (synchronous, active high) clears all valid bits and sets ignore_inside to 0
// and epsilon to 66.
module ray_box_intersect_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rbi_pkg::COORD_W-1:0]   req_origin_x,
   input  logic [rbi_pkg::COORD_W-1:0]   req_origin_y,
   input  logic [rbi_pkg::COORD_W-1:0]   req_origin_z,
   input  logic [rbi_pkg::COORD_W-1:0]   req_dir_x,
   input  logic [rbi_pkg::COORD_W-1:0]   req_dir_y,
   input  logic [rbi_pkg::COORD_W-1:0]   req_dir_z,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_min_x,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_min_y,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_min_z,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_max_x,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_max_y,
   input  logic [rbi_pkg::COORD_W-1:0]   req_box_max_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [rbi_pkg::DIST_W-1:0]    rsp_distance,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [rbi_pkg::EPS_W-1:0]     csr_wdata
);

   localparam int NS = rbi_pkg::DIV_STEPS;
   localparam int CW = rbi_pkg::COORD_W;
   localparam int DW = rbi_pkg::DIST_W;
   localparam int FB = rbi_pkg::FRAC_BITS;
   localparam int NW = rbi_pkg::NUM_W;
   localparam int PW = rbi_pkg::PROD_W;

   logic                          ign_ff;
   logic [rbi_pkg::EPS_W-1:0]     eps_ff;

   logic                          adv;

   rbi_pkg::item_type             item_in;
   logic                          inside_in;
   rbi_pkg::div_type [2:0]        div0_in;

   rbi_pkg::item_type             item_ff   [NS+1];
   logic                          vld_ff    [NS+1];
   logic                          inside_ff [NS+1];
   logic                          ign_p_ff  [NS+1];
   rbi_pkg::div_type [2:0]        div_ff    [NS+1];
   rbi_pkg::div_type [2:0]        div_in    [NS];

   rbi_pkg::item_type             m_item_ff;
   logic                          m_vld_ff, m_inside_ff, m_ign_ff;
   logic [2:0]                    m_tv_ff;
   logic [DW-1:0]                 m_t_ff [3];
   logic signed [PW-1:0]          m_prod_ff [3][2];
   logic [2:0]                    m_tv_in;
   logic [DW-1:0]                 m_t_in [3];
   logic signed [PW-1:0]          m_prod_in [3][2];

   logic                          c_vld_ff, c_inside_ff, c_ign_ff;
   logic [2:0]                    c_ok_ff;
   logic [DW-1:0]                 c_t_ff [3];
   logic [2:0]                    c_ok_in;

   logic                          rsp_valid_ff, rsp_hit_ff;
   logic [DW-1:0]                 rsp_distance_ff;
   logic                          rsp_hit_in;
   logic [DW-1:0]                 rsp_distance_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_ff <= 1'b0;
         eps_ff <= rbi_pkg::EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rbi_pkg::CSR_IGNORE_INSIDE: ign_ff <= csr_wdata[0];
            rbi_pkg::CSR_EPSILON:       eps_ff <= csr_wdata;
            default:                    ;
         endcase
      end
   end

   // Entry stage: inside test, near-face numerator, magnitudes and saturation check.
   always_comb begin
      logic signed [NW-1:0] num;
      logic [NW-1:0]        nmag;
      logic [CW-1:0]        dmag;
      logic                 dneg;
      item_in.o  = {req_origin_z, req_origin_y, req_origin_x};
      item_in.d  = {req_dir_z, req_dir_y, req_dir_x};
      item_in.lo = {req_box_min_z, req_box_min_y, req_box_min_x};
      item_in.hi = {req_box_max_z, req_box_max_y, req_box_max_x};
      inside_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if ($signed(item_in.o[a]) < $signed(item_in.lo[a]) ||
             $signed(item_in.o[a]) > $signed(item_in.hi[a])) begin
            inside_in = 1'b0;
         end
         dneg = item_in.d[a][CW-1];
         dmag = dneg ? CW'(-item_in.d[a]) : item_in.d[a];
         if (!dneg && item_in.d[a] != '0) begin
            num = $signed({item_in.lo[a][CW-1], item_in.lo[a]})
                - $signed({item_in.o[a][CW-1], item_in.o[a]});
         end else begin
            num = $signed({item_in.hi[a][CW-1], item_in.hi[a]})
                - $signed({item_in.o[a][CW-1], item_in.o[a]});
         end
         nmag = num[NW-1] ? NW'(-num) : NW'(num);
         div0_in[a].n    = nmag;
         div0_in[a].dm   = dmag;
         div0_in[a].rem  = CW'(nmag >> rbi_pkg::SAT_SHIFT);
         div0_in[a].quot = '0;
         div0_in[a].pos  = (dmag > {{(CW-rbi_pkg::EPS_W){1'b0}}, eps_ff}) &&
                           (num != '0) && (num[NW-1] == dneg);
         div0_in[a].sat  = {{rbi_pkg::SAT_SHIFT{1'b0}}, nmag} >=
                           {{(NW-CW){1'b0}}, dmag, {rbi_pkg::SAT_SHIFT{1'b0}}};
      end
   end

   // Restoring division, one quotient bit per stage and axis.
   always_comb begin
      logic [CW:0] trial;
      logic        xb;
      for (int k = 0; k < NS; k++) begin
         for (int a = 0; a < 3; a++) begin
            div_in[k][a] = div_ff[k][a];
            if (NS - 1 - k >= FB) begin
               xb = div_ff[k][a].n[NS - 1 - k - FB];
            end else begin
               xb = 1'b0;
            end
            trial = {div_ff[k][a].rem, xb};
            if (trial >= {1'b0, div_ff[k][a].dm}) begin
               div_in[k][a].rem  = CW'(trial - {1'b0, div_ff[k][a].dm});
               div_in[k][a].quot = {div_ff[k][a].quot[DW-2:0], 1'b1};
            end else begin
               div_in[k][a].rem  = trial[CW-1:0];
               div_in[k][a].quot = {div_ff[k][a].quot[DW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 0; k < NS; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0]   <= item_in;
         inside_ff[0] <= inside_in;
         ign_p_ff[0]  <= ign_ff;
         div_ff[0]    <= div0_in;
         for (int k = 0; k < NS; k++) begin
            item_ff[k+1]   <= item_ff[k];
            inside_ff[k+1] <= inside_ff[k];
            ign_p_ff[k+1]  <= ign_p_ff[k];
            div_ff[k+1]    <= div_in[k];
         end
      end
   end

   // Clamp t and form the hit-point products for the two other axes.
   always_comb begin
      int b;
      for (int a = 0; a < 3; a++) begin
         m_t_in[a]  = div_ff[NS][a].sat ? rbi_pkg::T_MAX : div_ff[NS][a].quot;
         m_tv_in[a] = div_ff[NS][a].pos &&
                      (div_ff[NS][a].sat || div_ff[NS][a].quot != '0);
         for (int j = 0; j < 2; j++) begin
            b = (a + 1 + j) % 3;
            m_prod_in[a][j] = $signed(item_ff[NS].d[b]) * $signed({1'b0, m_t_in[a]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_item_ff   <= item_ff[NS];
         m_inside_ff <= inside_ff[NS];
         m_ign_ff    <= ign_p_ff[NS];
         m_tv_ff     <= m_tv_in;
         m_t_ff      <= m_t_in;
         m_prod_ff   <= m_prod_in;
      end
   end

   // Slab check of the hit point; the arithmetic shift gives the floor.
   always_comb begin
      int b;
      logic signed [PW-1:0] p;
      for (int a = 0; a < 3; a++) begin
         c_ok_in[a] = m_tv_ff[a];
         for (int j = 0; j < 2; j++) begin
            b = (a + 1 + j) % 3;
            p = $signed({{(PW-CW){m_item_ff.o[b][CW-1]}}, m_item_ff.o[b]})
              + (m_prod_ff[a][j] >>> FB);
            if (p < $signed({{(PW-CW){m_item_ff.lo[b][CW-1]}}, m_item_ff.lo[b]}) ||
                p > $signed({{(PW-CW){m_item_ff.hi[b][CW-1]}}, m_item_ff.hi[b]})) begin
               c_ok_in[a] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_inside_ff <= m_inside_ff;
         c_ign_ff    <= m_ign_ff;
         c_ok_ff     <= c_ok_in;
         c_t_ff      <= m_t_ff;
      end
   end

   always_comb begin
      rsp_hit_in      = 1'b0;
      rsp_distance_in = '0;
      if (c_inside_ff) begin
         rsp_hit_in = !c_ign_ff;
      end else if (c_ok_ff[0]) begin
         rsp_hit_in      = 1'b1;
         rsp_distance_in = c_t_ff[0];
      end else if (c_ok_ff[1]) begin
         rsp_hit_in      = 1'b1;
         rsp_distance_in = c_t_ff[1];
      end else if (c_ok_ff[2]) begin
         rsp_hit_in      = 1'b1;
         rsp_distance_in = c_t_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_distance_ff <= rsp_distance_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;

   // A miss always reports zero distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == '0)
      else $error("miss with non-zero distance");

   // An inside origin reaching the output reports zero distance.
   assert property (@(posedge clock) disable iff (reset)
      adv && c_vld_ff && c_inside_ff |=> rsp_valid && rsp_distance == '0)
      else $error("inside origin with non-zero distance");

   // A saturated, positive x axis is clamped to T_MAX and stays valid at the multiply stage.
   assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[NS] && div_ff[NS][0].sat && div_ff[NS][0].pos
      |=> m_t_ff[0] == rbi_pkg::T_MAX && m_tv_ff[0])
      else $error("saturated t lost");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic                       hit;
      logic [rbi_pkg::DIST_W-1:0] distance;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rbi_pkg::coord_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   rbi_pkg::coord_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   rbi_pkg::coord_type req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   rbi_pkg::coord_type req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_hit;
   logic [rbi_pkg::DIST_W-1:0] rsp_distance;
   logic              csr_we = 1'b0;
   logic              csr_index = rbi_pkg::CSR_IGNORE_INSIDE;
   logic [rbi_pkg::EPS_W-1:0] csr_wdata = '0;

   rbi_pkg::item_type pending_rays[$];
   outcome_type expected_outcomes[$];
   rbi_pkg::item_type ray_on_bus;
   logic        cfg_ignore_inside = 1'b0;
   logic [rbi_pkg::EPS_W-1:0] cfg_epsilon = rbi_pkg::EPS_RESET;
   int          error_count = 0;
   int          gap_left = 0;
   int          burst_left = 4;
   int          stall_mode = 0;
   int          stall_timer = 0;

   ray_box_intersect_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z),
      .req_box_max_x(req_box_max_x), .req_box_max_y(req_box_max_y),
      .req_box_max_z(req_box_max_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic outcome_type intersect_ray(rbi_pkg::item_type r);
      longint o[3], d[3], lo[3], hi[3];
      longint num, t, p, mag;
      bit ok;
      outcome_type res;
      for (int k = 0; k < 3; k++) begin
         o[k] = longint'($signed(r.o[k]));
         d[k] = longint'($signed(r.d[k]));
         lo[k] = longint'($signed(r.lo[k]));
         hi[k] = longint'($signed(r.hi[k]));
      end
      res = '0;
      if (o[0] >= lo[0] && o[1] >= lo[1] && o[2] >= lo[2] &&
          o[0] <= hi[0] && o[1] <= hi[1] && o[2] <= hi[2]) begin
         res.hit = !cfg_ignore_inside;
         return res;
      end
      for (int a = 0; a < 3; a++) begin
         mag = d[a] < 0 ? -d[a] : d[a];
         if (mag <= longint'(cfg_epsilon)) continue;
         num = (d[a] > 0 ? lo[a] : hi[a]) - o[a];
         t = (num * (longint'(1) << rbi_pkg::FRAC_BITS)) / d[a];
         if (t <= 0) continue;
         if (t > longint'(rbi_pkg::T_MAX)) t = longint'(rbi_pkg::T_MAX);
         ok = 1'b1;
         for (int k = 0; k < 3; k++) begin
            if (k == a) continue;
            p = o[k] + ((d[k] * t) >>> rbi_pkg::FRAC_BITS);
            if (p < lo[k] || p > hi[k]) ok = 1'b0;
         end
         if (ok) begin
            res.hit = 1'b1;
            res.distance = t[rbi_pkg::DIST_W-1:0];
            return res;
         end
      end
      return res;
   endfunction

   function automatic rbi_pkg::coord_type near_coord(int span);
      return rbi_pkg::coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic rbi_pkg::item_type random_ray();
      rbi_pkg::item_type r;
      int kind;
      rbi_pkg::coord_type target;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         if (kind < 2) begin
            r.o[k] = $urandom;
            r.d[k] = $urandom;
            r.lo[k] = $urandom;
            r.hi[k] = $urandom;
         end else begin
            r.lo[k] = near_coord(8 << 16);
            r.hi[k] = r.lo[k] + $urandom_range(0, 4 << 16);
            target = r.lo[k] + $urandom_range(0, r.hi[k] - r.lo[k]);
            r.o[k] = near_coord(20 << 16);
            if (kind == 2) r.o[k] = target;
            r.d[k] = target - r.o[k];
            if (kind == 3) r.d[k] = near_coord(200);
            if (kind == 4) r.d[k] = -r.d[k];
            if (kind == 5) r.d[k] = near_coord(32 << 16);
            if (kind == 6 && $urandom_range(0, 2) == 0) r.d[k] = '0;
         end
      end
      return r;
   endfunction

   function automatic rbi_pkg::item_type make_ray(
         rbi_pkg::coord_type ox, oy, oz, dx, dy, dz,
         rbi_pkg::coord_type lx, ly, lz, hx, hy, hz);
      rbi_pkg::item_type r;
      r.o[0] = ox;  r.o[1] = oy;  r.o[2] = oz;
      r.d[0] = dx;  r.d[1] = dy;  r.d[2] = dz;
      r.lo[0] = lx; r.lo[1] = ly; r.lo[2] = lz;
      r.hi[0] = hx; r.hi[1] = hy; r.hi[2] = hz;
      return r;
   endfunction

   task automatic write_csr(logic idx, logic [rbi_pkg::EPS_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == rbi_pkg::CSR_IGNORE_INSIDE) cfg_ignore_inside = value[0];
      else cfg_epsilon = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_rays.size() == 0 && !req_valid && expected_outcomes.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_outcomes.push_back(intersect_ray(ray_on_bus));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_rays.size() > 0) begin
               ray_on_bus = pending_rays.pop_front();
               req_origin_x <= ray_on_bus.o[0];
               req_origin_y <= ray_on_bus.o[1];
               req_origin_z <= ray_on_bus.o[2];
               req_dir_x <= ray_on_bus.d[0];
               req_dir_y <= ray_on_bus.d[1];
               req_dir_z <= ray_on_bus.d[2];
               req_box_min_x <= ray_on_bus.lo[0];
               req_box_min_y <= ray_on_bus.lo[1];
               req_box_min_z <= ray_on_bus.lo[2];
               req_box_max_x <= ray_on_bus.hi[0];
               req_box_max_y <= ray_on_bus.hi[1];
               req_box_max_z <= ray_on_bus.hi[2];
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(16, 120);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (stall_timer[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result hit=%0b distance=%0h", $time, rsp_hit,
                     rsp_distance);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_distance !== want.distance) begin
               $display("%0t: distance expected %0h actual %0h", $time, want.distance,
                        rsp_distance);
               error_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      rbi_pkg::coord_type one;
      logic [rbi_pkg::EPS_W-1:0] eps_set[6];
      logic ign_set[6];
      one = 32'h0001_0000;
      eps_set = '{rbi_pkg::EPS_RESET, rbi_pkg::EPS_RESET, 16'd0, 16'hFFFF, 16'd1, 16'd0};
      ign_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rays: inside, faces, inverted box, small directions and saturation.
      pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(one, one, one, one, one, one,
                                      -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(-4*one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(4*one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(0, -4*one, 0, 0, one, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(0, 0, 4*one, 0, 0, -one, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(-4*one, 0, 0, 66, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(-4*one, 0, 0, 67, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(4*one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0, one, -one, -one, -one, one, one));
      pending_rays.push_back(make_ray(-4*one, 2*one, 0, one, one, 0,
                                      -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(-4*one, -one, 0, one, 0, 0,
                                      -one, -one, -one, one, one, one));
      pending_rays.push_back(make_ray(32'h8000_0000, 0, 0, 67, 0, 0,
                                      32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_rays.push_back(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_rays.push_back(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      pending_rays.push_back(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
      pending_rays.push_back(make_ray(-one, -one, -one, -1, -1, -1, 0, 0, 0, one, one, one));

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         if (phase == 5) begin
            write_csr(rbi_pkg::CSR_IGNORE_INSIDE,
                      (rbi_pkg::EPS_W)'($urandom_range(0, 1)));
            write_csr(rbi_pkg::CSR_EPSILON, (rbi_pkg::EPS_W)'($urandom_range(0, 65535)));
         end else begin
            write_csr(rbi_pkg::CSR_IGNORE_INSIDE, (rbi_pkg::EPS_W)'(ign_set[phase]));
            write_csr(rbi_pkg::CSR_EPSILON, eps_set[phase]);
         end
         if (phase == 1) begin
            pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0,
                                            -one, -one, -one, one, one, one));
            pending_rays.push_back(make_ray(-one, -one, -one, 0, 0, 0,
                                            -one, -one, -one, one, one, one));
         end
         for (int n = 0; n < 155; n++) pending_rays.push_back(random_ray());
      end
      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
